// ----- design/mp3f_pkg.sv -----
`default_nettype none

package mp3f_pkg;

  // action codes
  localparam logic [2:0] ActRxByte  = 3'd0;
  localparam logic [2:0] ActPlay    = 3'd1;
  localparam logic [2:0] ActVolume  = 3'd2;
  localparam logic [2:0] ActPause   = 3'd3;
  localparam logic [2:0] ActResume  = 3'd4;
  localparam logic [2:0] ActStorage = 3'd5;

  // frame bytes
  localparam logic [7:0] FrameStart = 8'h7E;
  localparam logic [7:0] FrameVer   = 8'hFF;
  localparam logic [7:0] FrameLen   = 8'h06;
  localparam logic [7:0] FrameEnd   = 8'hEF;
  localparam logic [7:0] FrameZero  = 8'h00;

  // command codes
  localparam logic [7:0] CmdPlay     = 8'h03;
  localparam logic [7:0] CmdVolume   = 8'h06;
  localparam logic [7:0] CmdPause    = 8'h0E;
  localparam logic [7:0] CmdResume   = 8'h0D;
  localparam logic [7:0] CmdStorage  = 8'h09;
  localparam logic [7:0] CmdFinished = 8'h3D;

  localparam logic [7:0] StorageData = 8'h02;
  localparam logic [7:0] VolMax      = 8'd30;
  localparam logic [7:0] VolNone     = 8'hFF;

  // receive matcher positions
  localparam logic [2:0] PosWaitStart = 3'd0;
  localparam logic [2:0] PosLastByte  = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic       playing;
    logic       finished_seen;
  } out_t;

  // one queued job: either a full command frame or a single idle result
  typedef struct packed {
    logic       is_frame;
    logic [7:0] cmd;
    logic [7:0] data_l;
    logic       playing;
    logic       finished;
  } job_t;

endpackage

`default_nettype wire

// ----- design/mp3_module_command_framer.sv -----
// An accepted item enters the job queue; the output register takes its first result when
// the serialiser starts on the job. A command frame is 8 bytes, sent one frame byte per cycle
// while the output is not stalled; a received byte or an idle item gives a single result.
// A short job queue lets the input side run ahead of the serialiser by QueueDepth items.
// Reset: asynchronous, active low; matcher waits for a start byte, not playing, no volume sent.
`default_nettype none

module mp3_module_command_framer #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  mp3f_pkg::in_t   in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output mp3f_pkg::out_t  out_data_o,
  input  wire             out_stall_i
);

  mp3f_pkg::job_t new_job, head_job;
  logic           q_full, q_valid, q_pop, in_accept;

  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  mp3f_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .job_o    (new_job)
  );

  mp3f_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (new_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_job)
  );

  mp3f_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_idle_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.tx_valid) |-> (out_data_o.last && out_data_o.tx_byte == 8'd0))
    else $error("idle result not single and zero");

  a_finished_not_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.finished_seen) |-> !out_data_o.playing)
    else $error("finished frame left playing set");

  a_frame_ends_with_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.tx_valid && out_data_o.last) |->
      (out_data_o.tx_byte == mp3f_pkg::FrameEnd))
    else $error("frame not closed by end byte");
`endif

endmodule

`default_nettype wire

// ----- design/mp3f_front.sv -----
`default_nettype none

module mp3f_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             accept_i,
  input  mp3f_pkg::in_t   item_i,
  output mp3f_pkg::job_t  job_o
);

  logic [2:0] frame_pos_q, frame_pos_d;
  logic [7:0] rx_cmd_q, rx_cmd_d;
  logic       playing_q, playing_d;
  logic [7:0] last_vol_q, last_vol_d;
  logic [7:0] vol_sat;
  logic       finished;

  assign vol_sat = (item_i.value > mp3f_pkg::VolMax) ? mp3f_pkg::VolMax : item_i.value;

  always_comb begin
    frame_pos_d = frame_pos_q;
    rx_cmd_d    = rx_cmd_q;
    playing_d   = playing_q;
    last_vol_d  = last_vol_q;
    finished    = 1'b0;
    job_o.is_frame = 1'b0;
    job_o.cmd      = mp3f_pkg::FrameZero;
    job_o.data_l   = mp3f_pkg::FrameZero;
    unique case (item_i.action)
      mp3f_pkg::ActRxByte: begin
        unique case (frame_pos_q)
          3'd0: frame_pos_d = (item_i.value == mp3f_pkg::FrameStart) ? 3'd1 : 3'd0;
          3'd1: frame_pos_d = (item_i.value == mp3f_pkg::FrameVer) ? 3'd2 : 3'd0;
          3'd2: frame_pos_d = (item_i.value == mp3f_pkg::FrameLen) ? 3'd3 : 3'd0;
          3'd3: begin
            rx_cmd_d    = item_i.value;
            frame_pos_d = 3'd4;
          end
          3'd4: frame_pos_d = 3'd5;
          3'd5: frame_pos_d = 3'd6;
          3'd6: frame_pos_d = mp3f_pkg::PosLastByte;
          default: begin
            if (item_i.value == mp3f_pkg::FrameEnd && rx_cmd_q == mp3f_pkg::CmdFinished) begin
              playing_d = 1'b0;
              finished  = 1'b1;
            end
            frame_pos_d = mp3f_pkg::PosWaitStart;
          end
        endcase
      end
      mp3f_pkg::ActPlay: begin
        if (item_i.value != 8'd0) begin
          playing_d      = 1'b1;
          job_o.is_frame = 1'b1;
          job_o.cmd      = mp3f_pkg::CmdPlay;
          job_o.data_l   = item_i.value;
        end
      end
      mp3f_pkg::ActVolume: begin
        if (vol_sat != last_vol_q) begin
          last_vol_d     = vol_sat;
          job_o.is_frame = 1'b1;
          job_o.cmd      = mp3f_pkg::CmdVolume;
          job_o.data_l   = vol_sat;
        end
      end
      mp3f_pkg::ActPause: begin
        playing_d      = 1'b0;
        job_o.is_frame = 1'b1;
        job_o.cmd      = mp3f_pkg::CmdPause;
      end
      mp3f_pkg::ActResume: begin
        playing_d      = 1'b1;
        job_o.is_frame = 1'b1;
        job_o.cmd      = mp3f_pkg::CmdResume;
      end
      mp3f_pkg::ActStorage: begin
        job_o.is_frame = 1'b1;
        job_o.cmd      = mp3f_pkg::CmdStorage;
        job_o.data_l   = mp3f_pkg::StorageData;
      end
      default: ; // unused codes give one idle result
    endcase
    job_o.playing  = playing_d;
    job_o.finished = finished;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q <= mp3f_pkg::PosWaitStart;
      rx_cmd_q    <= 8'd0;
      playing_q   <= 1'b0;
      last_vol_q  <= mp3f_pkg::VolNone;
    end else if (accept_i) begin
      frame_pos_q <= frame_pos_d;
      rx_cmd_q    <= rx_cmd_d;
      playing_q   <= playing_d;
      last_vol_q  <= last_vol_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/mp3f_queue.sv -----
`default_nettype none

module mp3f_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  mp3f_pkg::job_t  push_data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output mp3f_pkg::job_t  head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);
  localparam logic [AddrW-1:0] AddrOne  = AddrW'(1);
  localparam logic [CntW-1:0]  CntOne   = CntW'(1);

  mp3f_pkg::job_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrOne;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrOne;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntOne;
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/mp3f_back.sv -----
`default_nettype none

module mp3f_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             job_valid_i,
  input  mp3f_pkg::job_t  job_i,
  output logic            job_pop_o,
  output logic            out_valid_o,
  output mp3f_pkg::out_t  out_data_o,
  input  wire             out_stall_i
);

  logic [2:0]     idx_q, idx_d;
  logic           out_valid_q, out_valid_d;
  mp3f_pkg::out_t out_q, out_d;
  logic           take;
  logic           final_byte;
  logic [7:0]     frame_byte;

  // output register free or being emptied this cycle
  assign take       = job_valid_i && (!out_valid_q || !out_stall_i);
  assign final_byte = !job_i.is_frame || (idx_q == 3'd7);
  assign job_pop_o  = take && final_byte;

  always_comb begin
    unique case (idx_q)
      3'd0:    frame_byte = mp3f_pkg::FrameStart;
      3'd1:    frame_byte = mp3f_pkg::FrameVer;
      3'd2:    frame_byte = mp3f_pkg::FrameLen;
      3'd3:    frame_byte = job_i.cmd;
      3'd4:    frame_byte = mp3f_pkg::FrameZero;
      3'd5:    frame_byte = mp3f_pkg::FrameZero;   // data high is zero for every command
      3'd6:    frame_byte = job_i.data_l;
      default: frame_byte = mp3f_pkg::FrameEnd;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take) begin
      out_valid_d         = 1'b1;
      out_d.tx_byte       = job_i.is_frame ? frame_byte : 8'd0;
      out_d.tx_valid      = job_i.is_frame;
      out_d.last          = final_byte;
      out_d.playing       = job_i.playing;
      out_d.finished_seen = job_i.finished && !job_i.is_frame;
      idx_d               = final_byte ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mp3f_pkg::*;

  localparam logic [2:0] ActSpareA = 3'd6;
  localparam logic [2:0] ActSpareB = 3'd7;
  localparam int RandomItems = 210;
  localparam int HoldStart   = 400;
  localparam int HoldLen     = 300;

  class framer_scoreboard;
    out_t       expected_bytes[$];
    int         errors;
    logic [2:0] rx_pos;
    logic [7:0] rx_cmd;
    logic       playing;
    logic [7:0] vol_sent;

    function new();
      errors   = 0;
      rx_pos   = PosWaitStart;
      rx_cmd   = FrameZero;
      playing  = 1'b0;
      vol_sent = VolNone;
    endfunction

    function void push_result(logic [7:0] b, logic v, logic l, logic fin);
      out_t r;
      r.tx_byte       = b;
      r.tx_valid      = v;
      r.last          = l;
      r.playing       = playing;
      r.finished_seen = fin;
      expected_bytes.push_back(r);
    endfunction

    function void push_frame(logic [7:0] cmd, logic [7:0] dl);
      logic [7:0] frame_bytes [8];
      frame_bytes = '{FrameStart, FrameVer, FrameLen, cmd, FrameZero, FrameZero, dl, FrameEnd};
      for (int k = 0; k < 8; k++) push_result(frame_bytes[k], 1'b1, k == 7, 1'b0);
    endfunction

    function void note_event(in_t ev);
      logic       fin;
      logic [7:0] vol;
      fin = 1'b0;
      case (ev.action)
        ActRxByte: begin
          if (rx_pos == PosLastByte) begin
            if (ev.value == FrameEnd && rx_cmd == CmdFinished) begin
              playing = 1'b0;
              fin     = 1'b1;
            end
            rx_pos = PosWaitStart;
          end else if (rx_pos == PosWaitStart) begin
            rx_pos = (ev.value == FrameStart) ? 3'd1 : PosWaitStart;
          end else if (rx_pos == 3'd1) begin
            rx_pos = (ev.value == FrameVer) ? 3'd2 : PosWaitStart;
          end else if (rx_pos == 3'd2) begin
            rx_pos = (ev.value == FrameLen) ? 3'd3 : PosWaitStart;
          end else begin
            // position 3 holds the command, 4..6 are skipped
            if (rx_pos == 3'd3) rx_cmd = ev.value;
            rx_pos = rx_pos + 3'd1;
          end
          push_result(FrameZero, 1'b0, 1'b1, fin);
        end
        ActPlay: begin
          if (ev.value == FrameZero) begin
            push_result(FrameZero, 1'b0, 1'b1, 1'b0);
          end else begin
            playing = 1'b1;
            push_frame(CmdPlay, ev.value);
          end
        end
        ActVolume: begin
          vol = (ev.value > VolMax) ? VolMax : ev.value;
          if (vol == vol_sent) begin
            push_result(FrameZero, 1'b0, 1'b1, 1'b0);
          end else begin
            vol_sent = vol;
            push_frame(CmdVolume, vol);
          end
        end
        ActPause: begin
          playing = 1'b0;
          push_frame(CmdPause, FrameZero);
        end
        ActResume: begin
          playing = 1'b1;
          push_frame(CmdResume, FrameZero);
        end
        ActStorage: push_frame(CmdStorage, StorageData);
        default: push_result(FrameZero, 1'b0, 1'b1, 1'b0);
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_byte(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("tx_valid", want.tx_valid, got.tx_valid);
      compare_field("last", want.last, got.last);
      compare_field("playing", want.playing, got.playing);
      compare_field("finished_seen", want.finished_seen, got.finished_seen);
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  framer_scoreboard sb = new();
  int burst_left = 0;
  int sent_items = 0;

  mp3_module_command_framer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  always #4 clk = ~clk;

  task automatic send_event(input logic [2:0] act, input logic [7:0] val);
    in_t ev;
    ev.action = act;
    ev.value  = val;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst with no gaps
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
    if (act <= ActStorage) sent_items++;
  endtask

  task automatic send_rx_frame(input logic [7:0] cmd, input logic [7:0] tail, input bit broken);
    logic [7:0] frame_bytes [8];
    frame_bytes = '{FrameStart, FrameVer, FrameLen, cmd,
                    8'($urandom), 8'($urandom), 8'($urandom), tail};
    if (broken) frame_bytes[$urandom_range(0, 2)] = 8'($urandom);
    for (int k = 0; k < 8; k++) send_event(ActRxByte, frame_bytes[k]);
  endtask

  initial begin
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(ActRxByte, 8'h00);
    send_event(ActRxByte, 8'hFF);
    send_event(ActPlay, 8'h00);
    send_event(ActPlay, 8'hFF);
    send_event(ActVolume, 8'h00);
    send_event(ActVolume, 8'h00);      // same as last sent
    send_event(ActVolume, 8'hFF);      // saturates
    send_event(ActVolume, 8'd31);      // saturates to the value just sent
    send_event(ActVolume, 8'd29);
    send_event(ActPause, 8'hFF);
    send_event(ActResume, 8'h00);
    send_event(ActStorage, 8'hA5);
    send_event(ActSpareA, 8'h5A);
    send_event(ActSpareB, 8'hFF);
    send_rx_frame(CmdFinished, FrameEnd, 1'b0);
    send_event(ActPlay, 8'h01);

    sent_items = 0;
    while (sent_items < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_rx_frame((r < 25) ? CmdFinished : 8'($urandom),
                      ($urandom_range(0, 4) != 0) ? FrameEnd : 8'($urandom),
                      $urandom_range(0, 6) == 0);
      end else if (r < 45) begin
        send_event(ActRxByte, 8'($urandom));
      end else if (r < 55) begin
        send_event(ActPlay, ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom));
      end else if (r < 70) begin
        send_event(ActVolume, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 35)));
      end else if (r < 78) begin
        send_event(ActPause, 8'($urandom));
      end else if (r < 88) begin
        send_event(ActResume, 8'($urandom));
      end else if (r < 95) begin
        send_event(ActStorage, 8'($urandom));
      end else begin
        send_event($urandom_range(0, 1) ? ActSpareA : ActSpareB, 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: changing stall pattern, plus one long hold-off to fill the block
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      mode = (cyc / 150) % 4;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) begin
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ((cyc % 5) < 2);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte(out_data);
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mp3f_pkg.sv
design/mp3f_front.sv
design/mp3f_queue.sv
design/mp3f_back.sv
design/mp3_module_command_framer.sv
dv/tb.sv
